// ===== design/pdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic task dispatcher package
// Shared sizes, request codes and the structures that pass between the
// top level and the slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pdt_pkg;

	localparam int NUM_TASKS = 8;
	localparam int SLOT_W    = 3;
	localparam int IVL_W     = 8;
	localparam int ELAP_W    = 32;
	localparam int PHASE_W   = 8;
	localparam int PEND_W    = 16;
	localparam int REQ_W     = 2;
	localparam int CUR_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CNT_W     = $clog2(NUM_TASKS + 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK   = 2'd0,
		REQ_ADD    = 2'd1,
		REQ_TAKE   = 2'd2,
		REQ_DELETE = 2'd3
	} req_t;

	typedef struct packed {
		logic                fire;
		req_t                kind;
		logic [SLOT_W-1:0]   idx;
		logic [IVL_W-1:0]    ivl;
		logic                take_ok;
		logic                del_ok;
		logic [CUR_W-1:0]    cur_slot;
	} cmd_t;

	typedef struct packed {
		logic                found;
		logic [CUR_W-1:0]    slot;
		logic [CNT_W-1:0]    wraps;
	} chain_t;

endpackage

`default_nettype wire

// ===== design/periodic_task_dispatcher_core.sv =====
// ----------------------------------------------------------------------------
// Periodic task dispatcher core
// A row of slot cells with a shared pending-run counter and the record of
// the slot most recently taken.
//
//  Channel  Direction  Handshake             Fields
//  req      in         req_valid/req_stall   req_type, slot_index, new_interval
//  rsp      out        rsp_valid/rsp_stall   due_found, due_slot, pending_count
//
// Each request is completed in the cycle it is accepted; its response is
// registered and appears in the next cycle. While req_stall is low, one
// request per cycle is taken. The wrap count and the due-slot priority run
// as chains through the row of cells, which sets the critical path.
// The request side stalls only while a response is held by a stalled output.
// Reset clears every slot, the pending count and the taken-slot record.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_dispatcher_core
	import pdt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [REQ_W-1:0]  req_type,
	input  wire logic [SLOT_W-1:0] slot_index,
	input  wire logic [IVL_W-1:0]  new_interval,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic                   due_found,
	output logic [SLOT_W-1:0]      due_slot,
	output logic [PEND_W-1:0]      pending_count
);

	logic               accept;
	req_t               kind;
	cmd_t               cmd;
	chain_t             chain [NUM_TASKS+1];

	logic [PEND_W-1:0]  pend_q;
	logic               cur_valid_q;
	logic [CUR_W-1:0]   cur_slot_q;
	logic               rsp_valid_q;
	logic               found_q;
	logic [SLOT_W-1:0]  slot_q;

	logic [PEND_W:0]    pend_sum;
	logic [PEND_W-1:0]  pend_next;
	logic               take_ok;
	logic               take_found;
	logic [SLOT_W-1:0]  slot_out;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign kind      = req_t'(req_type);
	assign take_ok   = (pend_q != '0);

	always_comb begin
		cmd.fire     = accept;
		cmd.kind     = kind;
		cmd.idx      = slot_index;
		cmd.ivl      = new_interval;
		cmd.take_ok  = take_ok;
		cmd.del_ok   = cur_valid_q;
		cmd.cur_slot = cur_slot_q;
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
		pdt_slot_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_id   (CUR_W'(i)),
			.cmd       (cmd),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	assign take_found = take_ok && chain[NUM_TASKS].found;
	assign pend_sum   = {1'b0, pend_q} + (PEND_W+1)'(chain[NUM_TASKS].wraps);
	assign pend_next  = pend_sum[PEND_W] ? '1 : pend_sum[PEND_W-1:0];

	always_comb begin
		slot_out = '0;
		for (int b = 0; b < SLOT_W; b++) begin
			if (b < CUR_W) begin
				slot_out[b] = chain[NUM_TASKS].slot[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			slot_q      <= '0;
		end else begin
			if (accept) begin
				rsp_valid_q <= 1'b1;
				found_q     <= 1'b0;
				slot_q      <= '0;
				case (kind)
					REQ_TICK: begin
						pend_q <= pend_next;
					end
					REQ_TAKE: begin
						cur_valid_q <= take_found;
						if (take_found) begin
							pend_q     <= pend_q - PEND_W'(1);
							cur_slot_q <= chain[NUM_TASKS].slot;
							found_q    <= 1'b1;
							slot_q     <= slot_out;
						end
					end
					REQ_ADD, REQ_DELETE: begin
					end
					default: begin
					end
				endcase
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign due_found     = found_q;
	assign due_slot      = slot_q;
	assign pending_count = pend_q;

	a_take_records_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == REQ_TAKE && take_found) |=> (cur_valid_q && found_q))
		else $error("taken slot not recorded");

	a_take_lowers_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == REQ_TAKE && take_found) |=>
		(pend_q == $past(pend_q) - PEND_W'(1)))
		else $error("pending count not lowered by a take");

	a_tick_never_lowers: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == REQ_TICK) |=> (pend_q >= $past(pend_q)))
		else $error("pending count fell on a tick");

	a_add_delete_keep_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (kind == REQ_ADD || kind == REQ_DELETE)) |=> $stable(pend_q))
		else $error("pending count changed on add or delete");

	a_found_only_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind != REQ_TAKE) |=> !found_q)
		else $error("due slot reported for a request other than a take");

endmodule

`default_nettype wire

// ===== design/pdt_slot_cell.sv =====
// ----------------------------------------------------------------------------
// Periodic task dispatcher slot cell
// Holds the interval, elapsed count and phase of one task slot, adds its
// wrap to the count passed along the row and joins the priority chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pdt_slot_cell
	import pdt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CUR_W-1:0] cell_id,
	input  wire cmd_t             cmd,
	input  wire chain_t           chain_in,
	output chain_t                chain_out
);

	logic [IVL_W-1:0]   ivl_q;
	logic [ELAP_W-1:0]  elapsed_q;
	logic [PHASE_W-1:0] phase_q;

	logic               enabled;
	logic               due;
	logic [PHASE_W:0]   ph_inc;
	logic               wrap;
	logic               add_hit;
	logic               del_hit;
	logic               take_hit;

	assign enabled  = (ivl_q != '0);
	assign due      = enabled && (elapsed_q >= {{(ELAP_W-IVL_W){1'b0}}, ivl_q});
	assign ph_inc   = {1'b0, phase_q} + (PHASE_W+1)'(1);
	assign wrap     = enabled && (ph_inc >= {1'b0, ivl_q});
	assign add_hit  = (int'(cmd.idx) == int'(cell_id));
	assign del_hit  = cmd.del_ok && (cmd.cur_slot == cell_id);
	assign take_hit = cmd.take_ok && due && !chain_in.found;

	always_comb begin
		chain_out.found = chain_in.found || due;
		chain_out.slot  = chain_in.found ? chain_in.slot : cell_id;
		chain_out.wraps = chain_in.wraps + CNT_W'(wrap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ivl_q     <= '0;
			elapsed_q <= '0;
			phase_q   <= '0;
		end else if (cmd.fire) begin
			case (cmd.kind)
				REQ_TICK: begin
					if (elapsed_q != '1) begin
						elapsed_q <= elapsed_q + ELAP_W'(1);
					end
					if (!enabled || wrap) begin
						phase_q <= '0;
					end else begin
						phase_q <= ph_inc[PHASE_W-1:0];
					end
				end
				REQ_ADD: begin
					if (add_hit) begin
						ivl_q     <= cmd.ivl;
						elapsed_q <= '0;
						phase_q   <= '0;
					end
				end
				REQ_TAKE: begin
					if (take_hit) begin
						elapsed_q <= elapsed_q - {{(ELAP_W-IVL_W){1'b0}}, ivl_q};
					end
				end
				REQ_DELETE: begin
					if (del_hit) begin
						ivl_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire
